[src/firc_pkg.sv]
// Package for the flux interval rate classifier: sizes, codes, window limits,
// the command word passed from front to back, and the configuration set.
// No dependencies; the RTL files refer to it by scoped names, the bench imports it.
package firc_pkg;

    // Sizes of the block
    localparam int NUM_DRIVES  = 2;
    localparam int COUNT_WIDTH = 32;
    localparam int STAMP_WIDTH = 16;

    // Field widths of the channels
    localparam int KIND_W  = 2;
    localparam int DRV_W   = 2;
    localparam int RATE_W  = 3;
    localparam int CFG_W   = 16;
    localparam int SHARE_W = 7;
    localparam int CFG_IDX_W = 2;

    // Derived sizes
    localparam int DRV_IDX_W = (NUM_DRIVES > 1) ? $clog2(NUM_DRIVES) : 1;
    localparam int SEL_W     = $clog2(NUM_DRIVES + 1);
    localparam int NBINS     = 6;
    localparam int NWIN      = 5;
    localparam int BIN_W     = 3;
    localparam int VOTE_W    = COUNT_WIDTH + 3;
    localparam int VCMP_W    = (VOTE_W > CFG_W) ? VOTE_W : CFG_W;
    localparam int PTOP_W    = COUNT_WIDTH + 7;
    localparam int PVOTE_W   = VOTE_W + SHARE_W;
    localparam int PCT_FULL  = 100;

    // Command queue between front and back (depth is a power of two)
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [BIN_W-1:0]       OTHER_BIN    = BIN_W'(5);
    localparam logic [RATE_W-1:0]      RATE_UNKNOWN = RATE_W'(0);
    localparam logic [RATE_W-1:0]      RATE_MAX     = RATE_W'(5);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX      = '1;

    // Interval windows in capture ticks, tested in order
    localparam logic [STAMP_WIDTH-1:0] WIN_LO [NWIN] = '{
        STAMP_WIDTH'(12), STAMP_WIDTH'(16), STAMP_WIDTH'(18),
        STAMP_WIDTH'(26), STAMP_WIDTH'(30)
    };
    localparam logic [STAMP_WIDTH-1:0] WIN_HI [NWIN] = '{
        STAMP_WIDTH'(15), STAMP_WIDTH'(19), STAMP_WIDTH'(23),
        STAMP_WIDTH'(29), STAMP_WIDTH'(35)
    };

    typedef enum logic [KIND_W-1:0] {
        KIND_STAMP  = 2'd0,
        KIND_SELECT = 2'd1,
        KIND_DECIDE = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_VOTES  = 2'd0,
        CFG_TOP_SHARE  = 2'd1,
        CFG_NOISE_LOW  = 2'd2,
        CFG_NOISE_HIGH = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_COUNT  = 1'b0,
        OP_DECIDE = 1'b1
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [DRV_W-1:0] drive;
        logic [BIN_W-1:0] bin;
    } t_cmd;

    typedef struct packed {
        logic [CFG_W-1:0]   min_votes;
        logic [SHARE_W-1:0] top_share;
        logic [CFG_W-1:0]   noise_low;
        logic [CFG_W-1:0]   noise_high;
    } t_cfg;

endpackage

[src/firc_if.sv]
// Valid/ready channels of the flux interval rate classifier.
// Depends on firc_pkg for the field widths.
interface firc_item_if;
    logic                             valid;
    logic                             ready;
    logic [firc_pkg::KIND_W-1:0]      kind;
    logic [firc_pkg::STAMP_WIDTH-1:0] timestamp;
    logic [firc_pkg::DRV_W-1:0]       drive;

    modport source (output valid, kind, timestamp, drive, input ready);
    modport sink   (input valid, kind, timestamp, drive, output ready);
endinterface

interface firc_res_if;
    logic                         valid;
    logic                         ready;
    logic [firc_pkg::DRV_W-1:0]   decided_drive;
    logic [firc_pkg::RATE_W-1:0]  rate_code;

    modport source (output valid, decided_drive, rate_code, input ready);
    modport sink   (input valid, decided_drive, rate_code, output ready);
endinterface

[src/flux_interval_rate_classifier_core.sv]
// Top level of the flux interval rate classifier: configuration registers,
// front part, command queue and back part. Uses firc_pkg, firc_if and the
// firc_front, firc_queue and firc_back modules.
//
// Usage:
//   i_item carries one item per handshake: a capture timestamp, a drive
//   select change or a decide request (kind). o_res returns one item for each
//   decide request: the requested drive and the winning rate code.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata while
//   the block is idle; writes take effect at the next clock.
// Throughput: one item per cycle on both channels while no stall holds. The
//   front decodes and classifies in the cycle of acceptance; the back applies
//   one command per cycle from a four-entry queue unless a result waits.
// Decide path: a decide result passes the queue, four decide stages and the
//   result register.
// Reset: synchronous, clears all bin counts and stored timestamps, deselects
//   all drives and loads the default register values.
// Stall: while a result waits on o_res.ready the back holds; the queue keeps
//   taking items until it is full, then i_item.ready drops.
module flux_interval_rate_classifier_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    firc_item_if.sink                       i_item,
    firc_res_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [firc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [firc_pkg::CFG_W-1:0]      i_cfg_wdata
);

    firc_pkg::t_cfg r_cfg;
    firc_pkg::t_cmd w_cmd_in, w_cmd_out;
    logic           w_push, w_pop, w_full, w_empty;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_votes  <= firc_pkg::CFG_W'(50);
            r_cfg.top_share  <= firc_pkg::SHARE_W'(20);
            r_cfg.noise_low  <= firc_pkg::CFG_W'(4);
            r_cfg.noise_high <= firc_pkg::CFG_W'(49);
        end else if (i_cfg_we) begin
            case (firc_pkg::t_cfg_idx'(i_cfg_idx))
                firc_pkg::CFG_MIN_VOTES:  r_cfg.min_votes  <= i_cfg_wdata;
                firc_pkg::CFG_TOP_SHARE:  r_cfg.top_share  <= i_cfg_wdata[firc_pkg::SHARE_W-1:0];
                firc_pkg::CFG_NOISE_LOW:  r_cfg.noise_low  <= i_cfg_wdata;
                firc_pkg::CFG_NOISE_HIGH: r_cfg.noise_high <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    firc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cfg    (r_cfg),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_cmd    (w_cmd_in)
    );

    firc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_data  (w_cmd_out)
    );

    firc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (w_empty),
        .i_q_data  (w_cmd_out),
        .o_pop     (w_pop),
        .o_res     (o_res)
    );

endmodule

[src/firc_front.sv]
// Front part: accepts items, tracks the selected drive and its last stamp,
// classifies intervals and issues count/decide commands. Uses firc_pkg, firc_if.
module firc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    firc_item_if.sink           i_item,
    input  firc_pkg::t_cfg      i_cfg,
    input  logic                i_q_full,
    output logic                o_push,
    output firc_pkg::t_cmd      o_cmd
);

    logic [firc_pkg::SEL_W-1:0]       r_sel, n_sel;
    logic [firc_pkg::STAMP_WIDTH-1:0] r_last [firc_pkg::NUM_DRIVES];
    logic [firc_pkg::STAMP_WIDTH-1:0] n_last [firc_pkg::NUM_DRIVES];
    logic [firc_pkg::NUM_DRIVES-1:0]  r_sv, n_sv;

    logic                               w_acc;
    logic                               w_sel_ok;
    logic [firc_pkg::DRV_IDX_W-1:0]     w_sel_idx;
    logic [firc_pkg::STAMP_WIDTH-1:0]   w_dt;
    logic                               w_req_ok;
    logic [firc_pkg::SEL_W-1:0]         w_req;
    logic [firc_pkg::DRV_IDX_W-1:0]     w_req_idx;

    // Sort one interval: noise limits first, then windows, first match wins
    function automatic logic [firc_pkg::BIN_W-1:0] pick_bin(
        input logic [firc_pkg::STAMP_WIDTH-1:0] dt,
        input firc_pkg::t_cfg cfg
    );
        logic [firc_pkg::BIN_W-1:0] bin;
        logic                       found;
        bin   = firc_pkg::OTHER_BIN;
        found = 1'b0;
        if (dt >= cfg.noise_low && dt <= cfg.noise_high) begin
            for (int i = 0; i < firc_pkg::NWIN; i++) begin
                if (!found && dt >= firc_pkg::WIN_LO[i] && dt <= firc_pkg::WIN_HI[i]) begin
                    bin   = firc_pkg::BIN_W'(i);
                    found = 1'b1;
                end
            end
        end
        return bin;
    endfunction

    assign i_item.ready = !i_q_full;
    assign w_acc        = i_item.valid && !i_q_full;

    assign w_sel_ok  = r_sel < firc_pkg::SEL_W'(firc_pkg::NUM_DRIVES);
    assign w_sel_idx = r_sel[firc_pkg::DRV_IDX_W-1:0];
    assign w_dt      = i_item.timestamp - r_last[w_sel_idx];

    // Requested drive, folded to "none" when out of range
    assign w_req_ok  = {1'b0, i_item.drive} < (firc_pkg::DRV_W + 1)'(firc_pkg::NUM_DRIVES);
    assign w_req     = w_req_ok ? firc_pkg::SEL_W'(i_item.drive)
                                : firc_pkg::SEL_W'(firc_pkg::NUM_DRIVES);
    assign w_req_idx = i_item.drive[firc_pkg::DRV_IDX_W-1:0];

    // Item decode, state update and command issue
    always_comb begin
        n_sel  = r_sel;
        n_last = r_last;
        n_sv   = r_sv;
        o_push = 1'b0;
        o_cmd.op    = firc_pkg::OP_COUNT;
        o_cmd.drive = i_item.drive;
        o_cmd.bin   = pick_bin(w_dt, i_cfg);
        if (w_acc) begin
            case (firc_pkg::t_kind'(i_item.kind))
                firc_pkg::KIND_STAMP: begin
                    if (w_sel_ok) begin
                        n_last[w_sel_idx] = i_item.timestamp;
                        n_sv[w_sel_idx]   = 1'b1;
                        if (r_sv[w_sel_idx]) begin
                            o_push      = 1'b1;
                            o_cmd.drive = firc_pkg::DRV_W'(r_sel);
                        end
                    end
                end
                firc_pkg::KIND_SELECT: begin
                    if (w_req != r_sel) begin
                        if (w_req_ok) begin
                            n_sv[w_req_idx] = 1'b0;
                        end
                        n_sel = w_req;
                    end
                end
                firc_pkg::KIND_DECIDE: begin
                    o_push   = 1'b1;
                    o_cmd.op = firc_pkg::OP_DECIDE;
                end
                default: begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= firc_pkg::SEL_W'(firc_pkg::NUM_DRIVES);
            r_sv  <= '0;
            for (int i = 0; i < firc_pkg::NUM_DRIVES; i++) begin
                r_last[i] <= '0;
            end
        end else begin
            r_sel  <= n_sel;
            r_sv   <= n_sv;
            r_last <= n_last;
        end
    end

endmodule

[src/firc_queue.sv]
// Short command queue that decouples the front and back parts.
// Uses firc_pkg for depth and the command type.
module firc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  firc_pkg::t_cmd  i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output firc_pkg::t_cmd  o_data
);

    firc_pkg::t_cmd              r_mem [firc_pkg::QDEPTH];
    logic [firc_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [firc_pkg::QCNT_W-1:0] r_cnt;

    assign o_full  = r_cnt == firc_pkg::QCNT_W'(firc_pkg::QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[src/firc_back.sv]
// Back part: holds the per-drive bin counts, applies count commands and runs
// decide requests through a four-stage pipeline into the result register.
// Uses firc_pkg and firc_if.
module firc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  firc_pkg::t_cfg  i_cfg,
    input  logic            i_q_empty,
    input  firc_pkg::t_cmd  i_q_data,
    output logic            o_pop,
    firc_res_if.source      o_res
);

    localparam int CW = firc_pkg::COUNT_WIDTH;
    localparam int NW = firc_pkg::NWIN;

    logic [CW-1:0] r_cnt [firc_pkg::NUM_DRIVES][firc_pkg::NBINS];

    logic                            w_adv;
    logic                            w_ok;
    logic [firc_pkg::DRV_IDX_W-1:0]  w_idx;

    // Stage 1: snapshot of the drive's window counts
    logic                       r_s1_vld, r_s1_ok;
    logic [firc_pkg::DRV_W-1:0] r_s1_drv;
    logic [CW-1:0]              r_s1_c [NW];
    // Stage 2: pair sums and pair winners
    logic                       r_s2_vld, r_s2_ok;
    logic [firc_pkg::DRV_W-1:0] r_s2_drv;
    logic [CW:0]                r_s2_s01, r_s2_s23;
    logic [CW-1:0]              r_s2_c4, r_s2_v01, r_s2_v23;
    logic [firc_pkg::BIN_W-1:0] r_s2_t01, r_s2_t23;
    // Stage 3: vote total and top bin
    logic                       r_s3_vld, r_s3_ok;
    logic [firc_pkg::DRV_W-1:0] r_s3_drv;
    logic [firc_pkg::VOTE_W-1:0] r_s3_votes;
    logic [CW-1:0]              r_s3_tval;
    logic [firc_pkg::BIN_W-1:0] r_s3_top;
    // Stage 4: share products
    logic                        r_s4_vld, r_s4_ok;
    logic [firc_pkg::DRV_W-1:0]  r_s4_drv;
    logic                        r_s4_enough;
    logic [firc_pkg::PTOP_W-1:0] r_s4_ptop;
    logic [firc_pkg::PVOTE_W-1:0] r_s4_pvotes;
    logic [firc_pkg::BIN_W-1:0]  r_s4_top;
    // Result register
    logic                        r_out_vld;
    logic [firc_pkg::DRV_W-1:0]  r_out_drv;
    logic [firc_pkg::RATE_W-1:0] r_out_code;

    logic [firc_pkg::BIN_W-1:0]  n_s3_top;
    logic [CW-1:0]               n_s3_tval;
    logic [firc_pkg::RATE_W-1:0] n_out_code;

    // Whole back pipeline moves unless the result waits on the receiver
    assign w_adv = !r_out_vld || o_res.ready;
    assign o_pop = w_adv && !i_q_empty;
    assign w_ok  = {1'b0, i_q_data.drive} < (firc_pkg::DRV_W + 1)'(firc_pkg::NUM_DRIVES);
    assign w_idx = i_q_data.drive[firc_pkg::DRV_IDX_W-1:0];

    // Bin counts: saturating increment, or clear of the row on a decide
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < firc_pkg::NUM_DRIVES; d++) begin
                for (int b = 0; b < firc_pkg::NBINS; b++) begin
                    r_cnt[d][b] <= '0;
                end
            end
        end else if (o_pop && w_ok) begin
            if (i_q_data.op == firc_pkg::OP_COUNT) begin
                if (r_cnt[w_idx][i_q_data.bin] != firc_pkg::CNT_MAX) begin
                    r_cnt[w_idx][i_q_data.bin] <= r_cnt[w_idx][i_q_data.bin] + 1'b1;
                end
            end else begin
                for (int b = 0; b < firc_pkg::NBINS; b++) begin
                    r_cnt[w_idx][b] <= '0;
                end
            end
        end
    end

    // Top of the two pair winners and bin 4, lower index on ties
    always_comb begin
        if (r_s2_v23 > r_s2_v01) begin
            n_s3_top  = r_s2_t23;
            n_s3_tval = r_s2_v23;
        end else begin
            n_s3_top  = r_s2_t01;
            n_s3_tval = r_s2_v01;
        end
        if (r_s2_c4 > n_s3_tval) begin
            n_s3_top  = firc_pkg::BIN_W'(4);
            n_s3_tval = r_s2_c4;
        end
    end

    // Final decision
    always_comb begin
        n_out_code = firc_pkg::RATE_UNKNOWN;
        if (r_s4_ok && r_s4_enough
                && firc_pkg::PVOTE_W'(r_s4_ptop) >= r_s4_pvotes) begin
            n_out_code = firc_pkg::RATE_W'(r_s4_top + 1'b1);
        end
    end

    // Valid bits of the decide pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld  <= o_pop && i_q_data.op == firc_pkg::OP_DECIDE;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_out_vld <= r_s4_vld;
        end
    end

    // Payload of the decide pipeline
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_ok  <= w_ok;
            r_s1_drv <= i_q_data.drive;
            for (int b = 0; b < NW; b++) begin
                r_s1_c[b] <= r_cnt[w_idx][b];
            end

            r_s2_ok  <= r_s1_ok;
            r_s2_drv <= r_s1_drv;
            r_s2_s01 <= {1'b0, r_s1_c[0]} + {1'b0, r_s1_c[1]};
            r_s2_s23 <= {1'b0, r_s1_c[2]} + {1'b0, r_s1_c[3]};
            r_s2_c4  <= r_s1_c[4];
            if (r_s1_c[1] > r_s1_c[0]) begin
                r_s2_t01 <= firc_pkg::BIN_W'(1);
                r_s2_v01 <= r_s1_c[1];
            end else begin
                r_s2_t01 <= firc_pkg::BIN_W'(0);
                r_s2_v01 <= r_s1_c[0];
            end
            if (r_s1_c[3] > r_s1_c[2]) begin
                r_s2_t23 <= firc_pkg::BIN_W'(3);
                r_s2_v23 <= r_s1_c[3];
            end else begin
                r_s2_t23 <= firc_pkg::BIN_W'(2);
                r_s2_v23 <= r_s1_c[2];
            end

            r_s3_ok    <= r_s2_ok;
            r_s3_drv   <= r_s2_drv;
            r_s3_votes <= firc_pkg::VOTE_W'(r_s2_s01) + firc_pkg::VOTE_W'(r_s2_s23)
                        + firc_pkg::VOTE_W'(r_s2_c4);
            r_s3_top   <= n_s3_top;
            r_s3_tval  <= n_s3_tval;

            r_s4_ok     <= r_s3_ok;
            r_s4_drv    <= r_s3_drv;
            r_s4_top    <= r_s3_top;
            r_s4_enough <= firc_pkg::VCMP_W'(r_s3_votes) >= firc_pkg::VCMP_W'(i_cfg.min_votes);
            r_s4_ptop   <= firc_pkg::PTOP_W'(r_s3_tval) * firc_pkg::PTOP_W'(firc_pkg::PCT_FULL);
            r_s4_pvotes <= firc_pkg::PVOTE_W'(r_s3_votes) * firc_pkg::PVOTE_W'(i_cfg.top_share);

            r_out_drv  <= r_s4_drv;
            r_out_code <= n_out_code;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.decided_drive = r_out_drv;
    assign o_res.rate_code     = r_out_code;

    // A decide for a real drive leaves that drive's first bin and other bin empty
    a_decide_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && w_ok && i_q_data.op == firc_pkg::OP_DECIDE)
        |=> (r_cnt[$past(w_idx)][0] == '0
             && r_cnt[$past(w_idx)][firc_pkg::OTHER_BIN] == '0))
        else $error("decide did not clear the drive's bins");

    // Rate codes stay within the defined set
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_out_code <= firc_pkg::RATE_MAX)
        else $error("rate code out of range");

    // Only a real drive can win a rate
    a_none_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_code != firc_pkg::RATE_UNKNOWN)
        |-> ({1'b0, r_out_drv} < (firc_pkg::DRV_W + 1)'(firc_pkg::NUM_DRIVES)))
        else $error("rate decided for no drive");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for flux_interval_rate_classifier_core: random interval bursts,
// decide requests and register settings, checked against a behavioral vote tracker.
// Depends on firc_pkg, firc_if and the core RTL.
import firc_pkg::*;

typedef struct packed {
    logic [DRV_W-1:0]  drive;
    logic [RATE_W-1:0] rate;
} decision_t;

// Behavioral copy of the classifier: per-drive stamps and bin counts, plus the
// decisions still owed by the block, oldest first.
class rate_vote_tracker;
    logic [CFG_W-1:0]       min_votes;
    logic [SHARE_W-1:0]     top_share;
    logic [CFG_W-1:0]       noise_low;
    logic [CFG_W-1:0]       noise_high;
    logic [STAMP_WIDTH-1:0] last_stamp [NUM_DRIVES];
    bit                     stamp_ok [NUM_DRIVES];
    logic [COUNT_WIDTH-1:0] counts [NUM_DRIVES][NBINS];
    int unsigned            sel;
    decision_t              owed_q[$];
    int unsigned            mismatches;

    function new();
        min_votes  = 50;
        top_share  = 20;
        noise_low  = 4;
        noise_high = 49;
        sel        = NUM_DRIVES;
        mismatches = 0;
        foreach (last_stamp[d]) begin
            last_stamp[d] = '0;
            stamp_ok[d]   = 1'b0;
        end
        foreach (counts[d, b]) counts[d][b] = '0;
    endfunction

    function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] v);
        case (idx)
            CFG_MIN_VOTES:  min_votes  = v;
            CFG_TOP_SHARE:  top_share  = v[SHARE_W-1:0];
            CFG_NOISE_LOW:  noise_low  = v;
            CFG_NOISE_HIGH: noise_high = v;
            default: ;
        endcase
    endfunction

    // Noise limits first, then the windows in order; first hit wins
    function int bin_of(logic [STAMP_WIDTH-1:0] dt);
        if (dt < noise_low || dt > noise_high) return int'(OTHER_BIN);
        if (dt >= 12 && dt <= 15) return 0;
        if (dt >= 16 && dt <= 19) return 1;
        if (dt >= 18 && dt <= 23) return 2;
        if (dt >= 26 && dt <= 29) return 3;
        if (dt >= 30 && dt <= 35) return 4;
        return int'(OTHER_BIN);
    endfunction

    // Winning rate for a drive; clears its counts whatever the outcome
    function logic [RATE_W-1:0] decide(int unsigned d);
        logic [COUNT_WIDTH-1:0] c [NWIN];
        logic [63:0]            votes;
        int                     top;
        if (d >= NUM_DRIVES) return RATE_UNKNOWN;
        votes = '0;
        for (int i = 0; i < NWIN; i++) begin
            c[i]  = counts[d][i];
            votes = votes + 64'(c[i]);
        end
        for (int i = 0; i < NBINS; i++) counts[d][i] = '0;
        if (votes < 64'(min_votes)) return RATE_UNKNOWN;
        top = 0;
        for (int i = 1; i < NWIN; i++)
            if (c[i] > c[top]) top = i;
        if (64'(c[top]) * 64'd100 < votes * 64'(top_share)) return RATE_UNKNOWN;
        return RATE_W'(top + 1);
    endfunction

    function void note_item(t_kind k, logic [STAMP_WIDTH-1:0] ts, logic [DRV_W-1:0] drv);
        logic [STAMP_WIDTH-1:0] dt;
        int                     b;
        int unsigned            d;
        decision_t              want;
        case (k)
            KIND_STAMP: begin
                if (sel < NUM_DRIVES) begin
                    if (!stamp_ok[sel]) begin
                        // first sample after a select only sets the reference
                        last_stamp[sel] = ts;
                        stamp_ok[sel]   = 1'b1;
                    end else begin
                        dt = ts - last_stamp[sel];
                        last_stamp[sel] = ts;
                        b = bin_of(dt);
                        if (counts[sel][b] != CNT_MAX) counts[sel][b] = counts[sel][b] + 1'b1;
                    end
                end
            end
            KIND_SELECT: begin
                d = (drv >= NUM_DRIVES) ? NUM_DRIVES : drv;
                if (d != sel) begin
                    if (d < NUM_DRIVES) stamp_ok[d] = 1'b0;
                    sel = d;
                end
            end
            KIND_DECIDE: begin
                want.drive = drv;
                want.rate  = decide(drv);
                owed_q.push_back(want);
            end
            default: ;
        endcase
    endfunction

    function void flag(string msg);
        mismatches++;
        if (mismatches <= 10) $display("[%0t] %s", $time, msg);
    endfunction

    function void check_decision(logic [DRV_W-1:0] drv, logic [RATE_W-1:0] rate);
        decision_t want;
        if (owed_q.size() == 0) begin
            flag($sformatf("unexpected decision: drive %0d rate %0d", drv, rate));
            return;
        end
        want = owed_q.pop_front();
        if (want.drive !== drv || want.rate !== rate)
            flag($sformatf("decision wrong: expected drive %0d rate %0d, got drive %0d rate %0d",
                           want.drive, want.rate, drv, rate));
    endfunction

    function int unsigned owed();
        return owed_q.size();
    endfunction
endclass

module testbench;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 150;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TICK_LO [NWIN] = '{12, 16, 18, 26, 30};
    localparam int TICK_HI [NWIN] = '{15, 19, 23, 29, 35};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_wdata;

    firc_item_if item_ch ();
    firc_res_if  res_ch ();

    flux_interval_rate_classifier_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch),
        .o_res       (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    rate_vote_tracker       votes;
    bit                     no_idle;
    bit                     hold_rx;
    int                     sent_items;
    int                     stalled_cycles;
    logic [STAMP_WIDTH-1:0] stamp_now;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                hold_rx = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            res_ch.ready <= no_idle || ($urandom_range(99) >= 18);
        end
    end

    // Check results and watch for a hung block
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
                votes.check_decision(res_ch.decided_drive, res_ch.rate_code);
            if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Offer one item, with a random gap first, and hold it until taken
    task automatic send_item(t_kind k, logic [STAMP_WIDTH-1:0] ts, logic [DRV_W-1:0] drv);
        int gap;
        gap = (!no_idle && $urandom_range(99) < 18) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            item_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        item_ch.valid     <= 1'b1;
        item_ch.kind      <= k;
        item_ch.timestamp <= ts;
        item_ch.drive     <= drv;
        do @(posedge i_clk); while (!(item_ch.valid === 1'b1 && item_ch.ready === 1'b1));
        votes.note_item(k, ts, drv);
        if (k != KIND_NONE) sent_items++;
    endtask

    // Stop offering, let every owed decision arrive, then let the queue drain
    task automatic settle();
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
        while (votes.owed() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= v;
        votes.write_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic program_limits(int unsigned mv, int unsigned share, int unsigned lo,
                                  int unsigned hi);
        write_reg(CFG_MIN_VOTES, CFG_W'(mv));
        write_reg(CFG_TOP_SHARE, CFG_W'(share));
        write_reg(CFG_NOISE_LOW, CFG_W'(lo));
        write_reg(CFG_NOISE_HIGH, CFG_W'(hi));
    endtask

    task automatic send_stamp(int dt);
        stamp_now = stamp_now + STAMP_WIDTH'(dt);
        send_item(KIND_STAMP, stamp_now, DRV_W'($urandom));
    endtask

    function automatic int tick_in(int w);
        return $urandom_range(TICK_LO[w], TICK_HI[w]);
    endfunction

    // Interval that falls in no window: short, in the gap, long, or anything
    function automatic int off_window();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 11);
            1: return $urandom_range(24, 25);
            2: return $urandom_range(36, 70);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // Select a drive, feed a run of intervals, then ask for the decision
    task automatic play_burst();
        int d;
        int w;
        int w2;
        int len;
        int style;
        d   = ($urandom_range(99) < 90) ? $urandom_range(0, 1) : $urandom_range(2, 3);
        len = ($urandom_range(99) < 10) ? $urandom_range(40, 70) : $urandom_range(1, 30);
        w   = $urandom_range(0, NWIN - 1);
        w2  = $urandom_range(0, NWIN - 1);
        style = $urandom_range(99);
        send_item(KIND_SELECT, STAMP_WIDTH'($urandom), DRV_W'(d));
        for (int i = 0; i < len; i++) begin
            if (style < 40)
                send_stamp(($urandom_range(99) < 85) ? tick_in(w) : off_window());
            else if (style < 60)
                send_stamp(tick_in((i % 2) ? w2 : w));    // two windows, even -> tie
            else if (style < 80)
                send_stamp(tick_in($urandom_range(0, NWIN - 1)));
            else
                send_stamp(($urandom_range(99) < 50) ? tick_in(w) : off_window());
        end
        send_item(KIND_DECIDE, STAMP_WIDTH'($urandom),
                  ($urandom_range(99) < 85) ? DRV_W'(d) : DRV_W'($urandom));
    endtask

    task automatic run_phase(int n);
        int goal;
        goal = sent_items + n;
        while (sent_items < goal) begin
            if ($urandom_range(99) < 80)
                play_burst();
            else
                send_item(t_kind'($urandom_range(0, 3)), STAMP_WIDTH'($urandom),
                          DRV_W'($urandom));
        end
    endtask

    initial begin
        votes          = new();
        no_idle        = 1'b0;
        hold_rx        = 1'b0;
        sent_items     = 0;
        stalled_cycles = 0;
        stamp_now      = STAMP_WIDTH'($urandom);
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_MIN_VOTES;
        i_cfg_wdata    = '0;
        item_ch.valid     = 1'b0;
        item_ch.kind      = KIND_STAMP;
        item_ch.timestamp = '0;
        item_ch.drive     = '0;
        res_ch.ready      = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle drives, codes for none, wrap, window overlap, noise edges
        send_item(KIND_STAMP, 16'h1234, 2'd0);     // nothing selected: ignored
        send_item(KIND_DECIDE, 16'h0000, 2'd2);    // decide for none
        send_item(KIND_DECIDE, 16'hFFFF, 2'd3);    // out-of-range drive code
        send_item(KIND_NONE, 16'hFFFF, 2'd3);      // unused kind
        send_item(KIND_SELECT, 16'h0000, 2'd3);    // none again: no change
        send_item(KIND_SELECT, 16'h0000, 2'd0);
        send_item(KIND_STAMP, 16'hFFF8, 2'd0);     // reference only
        send_item(KIND_STAMP, 16'h0006, 2'd0);     // wraps, 14 ticks
        send_item(KIND_STAMP, 16'h0018, 2'd0);     // 18: overlap goes to bin 1, the first matching window
        send_item(KIND_STAMP, 16'h002B, 2'd0);     // 19
        send_item(KIND_SELECT, 16'h0000, 2'd0);    // same drive: stamp stays valid
        send_item(KIND_STAMP, 16'h002E, 2'd0);     // below noise floor
        send_item(KIND_STAMP, 16'h0060, 2'd0);     // above noise ceiling
        send_item(KIND_STAMP, 16'h0091, 2'd0);     // at ceiling, no window
        send_item(KIND_STAMP, 16'h00B4, 2'd0);     // 35
        send_item(KIND_STAMP, 16'h00B4, 2'd0);     // zero interval
        send_item(KIND_SELECT, 16'h0000, 2'd1);
        send_item(KIND_STAMP, 16'h0000, 2'd1);
        send_item(KIND_STAMP, 16'h001B, 2'd1);     // 27
        send_item(KIND_SELECT, 16'h0000, 2'd0);    // reselect drops drive 0's stamp
        send_item(KIND_STAMP, 16'h0100, 2'd0);
        send_item(KIND_STAMP, 16'h0114, 2'd0);     // 20
        send_item(KIND_DECIDE, 16'h0000, 2'd0);    // too few votes
        send_item(KIND_DECIDE, 16'h0000, 2'd1);
        send_item(KIND_SELECT, 16'hFFFF, 2'd2);
        settle();

        // Widest limits, no idling on either side; zero votes pass a zero minimum
        no_idle = 1'b1;
        program_limits(0, 0, 0, 65535);
        send_item(KIND_DECIDE, 16'h0000, 2'd0);
        send_item(KIND_SELECT, 16'h0000, 2'd0);
        send_item(KIND_STAMP, 16'h0000, 2'd0);
        send_item(KIND_STAMP, 16'hFFFF, 2'd0);     // largest interval
        send_item(KIND_STAMP, 16'h000C, 2'd0);
        send_item(KIND_DECIDE, 16'h0000, 2'd0);
        run_phase(100);
        settle();
        no_idle = 1'b0;

        program_limits(65535, 100, 0, 65535);
        run_phase(90);
        settle();

        // Share above 100 percent always fails once there are votes
        program_limits(4, 127, 4, 49);
        run_phase(90);
        settle();

        // Crossed noise limits: everything is other
        program_limits(6, 50, 40, 10);
        run_phase(80);
        settle();

        // Long result hold-off while items keep coming, so the input stalls
        program_limits(8, 60, 12, 35);
        hold_rx = 1'b1;
        for (int i = 0; i < 12; i++)
            send_item(KIND_DECIDE, STAMP_WIDTH'($urandom), DRV_W'($urandom));
        run_phase(60);
        settle();
        run_phase(60);
        settle();

        program_limits(5, 30, 17, 100);
        run_phase(100);
        settle();

        for (int p = 0; p < 2; p++) begin
            program_limits($urandom_range(0, 24), $urandom_range(0, 100),
                           $urandom_range(0, 20), $urandom_range(20, 80));
            run_phase(110);
            settle();
        end

        program_limits(3, 100, 12, 35);
        run_phase(80);
        settle();

        program_limits(50, 20, 4, 49);
        run_phase(110);
        settle();

        if (votes.mismatches == 0 && votes.owed() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
